// ===== rtl/ksr_pkg.sv =====
`timescale 1ns / 1ps

package ksr_pkg;

  localparam int DEPTH_DEF    = 8;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_e;

endpackage

// ===== rtl/ksr_if.sv =====
`timescale 1ns / 1ps

interface ksr_in_if;
  logic                       valid;
  logic                       ready;
  logic [ksr_pkg::OP_W-1:0]  operation;
  logic [ksr_pkg::KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface ksr_out_if;
  logic                          valid;
  logic                          ready;
  logic [ksr_pkg::STATUS_W-1:0] status;
  logic [ksr_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

// ===== rtl/keyed_stack_with_removal.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                         Beat when
// in_i     in   operation[1:0], key[31:0]       valid & ready
// out_o    out  status[1:0], count[3:0]         valid & ready
//
// One item at a time; ready is high only while the sequencer idles.
// Push writes the entry on acceptance. Search reads and compares each entry from the top.
// Remove: scan as search, then read and write back each entry above the match to move it down.
// Reset clears the entry count and the output valid flag; store contents undefined.
// A stalled result holds in the output register; the next item is taken meanwhile.

module keyed_stack_with_removal #(
  parameter int DEPTH    = ksr_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ksr_pkg::KEY_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ksr_in_if.sink   in_i,
  ksr_out_if.source out_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ksr_pkg::state_e  state_q, state_d;
  ksr_pkg::op_e     op_q, op_d;
  ksr_pkg::status_e res_q, res_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;

  logic                         out_valid_q, out_valid_d;
  ksr_pkg::status_e             out_status_q, out_status_d;
  logic [ksr_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [KEY_BITS-1:0] rd_data;
  logic                more_above;

  ksr_store #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // an entry sits above the current index
  assign more_above = (CNT_W'(idx_q) + 1'b1) < count_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    res_d        = res_q;
    key_d        = key_q;
    count_d      = count_q;
    idx_d        = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rd_data;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    case (state_q)
      ksr_pkg::S_IDLE: begin
        if (in_i.valid) begin
          key_d = KEY_BITS'(in_i.key);
          op_d  = ksr_pkg::op_e'(in_i.operation);
          case (ksr_pkg::op_e'(in_i.operation))
            ksr_pkg::OP_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_d = ksr_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[IDX_W-1:0];
                wr_data = KEY_BITS'(in_i.key);
                count_d = count_q + 1'b1;
                res_d   = ksr_pkg::ST_OK;
              end
              state_d = ksr_pkg::S_DONE;
            end
            ksr_pkg::OP_REMOVE: begin
              if (count_q == '0) begin
                res_d   = ksr_pkg::ST_EMPTY;
                state_d = ksr_pkg::S_DONE;
              end else begin
                idx_d   = IDX_W'(count_q - 1'b1);
                state_d = ksr_pkg::S_RD;
              end
            end
            default: begin
              // search; the unused code behaves as search too
              if (count_q == '0) begin
                res_d   = ksr_pkg::ST_NOT_FOUND;
                state_d = ksr_pkg::S_DONE;
              end else begin
                idx_d   = IDX_W'(count_q - 1'b1);
                state_d = ksr_pkg::S_RD;
              end
            end
          endcase
        end
      end
      ksr_pkg::S_RD: begin
        state_d = ksr_pkg::S_CMP;
      end
      ksr_pkg::S_CMP: begin
        if (rd_data == key_q) begin
          res_d = ksr_pkg::ST_OK;
          if (op_q == ksr_pkg::OP_REMOVE && more_above) begin
            idx_d   = idx_q + 1'b1;
            state_d = ksr_pkg::S_SHRD;
          end else begin
            if (op_q == ksr_pkg::OP_REMOVE) begin
              count_d = count_q - 1'b1;
            end
            state_d = ksr_pkg::S_DONE;
          end
        end else if (idx_q == '0) begin
          res_d   = ksr_pkg::ST_NOT_FOUND;
          state_d = ksr_pkg::S_DONE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ksr_pkg::S_RD;
        end
      end
      ksr_pkg::S_SHRD: begin
        state_d = ksr_pkg::S_SHWR;
      end
      ksr_pkg::S_SHWR: begin
        // move entry idx down into idx-1
        wr_en   = 1'b1;
        wr_addr = idx_q - 1'b1;
        wr_data = rd_data;
        if (more_above) begin
          idx_d   = idx_q + 1'b1;
          state_d = ksr_pkg::S_SHRD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ksr_pkg::S_DONE;
        end
      end
      ksr_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_count_d  = ksr_pkg::COUNT_W'(count_q);
          state_d      = ksr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ksr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksr_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    res_q        <= res_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign in_i.ready   = (state_q == ksr_pkg::S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.count  = out_count_q;

endmodule

// ===== rtl/ksr_store.sv =====
`timescale 1ns / 1ps

module ksr_store #(
  parameter int DEPTH    = ksr_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ksr_pkg::KEY_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [KEY_BITS-1:0]      wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [KEY_BITS-1:0]      rd_data_o
);

  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [KEY_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/ksr_checker.sv =====
`timescale 1ns / 1ps

module ksr_checker #(
  parameter int DEPTH = ksr_pkg::DEPTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ksr_pkg::STATUS_W-1:0]  out_status_i,
  input logic [ksr_pkg::COUNT_W-1:0]   out_count_i
);

  // one item in flight: ready drops right after an input beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_status_i)
                                       && $stable(out_count_i)))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((DEPTH > 15) || (out_count_i <= ksr_pkg::COUNT_W'(DEPTH))))
    else $error("count above depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_status_i == ksr_pkg::ST_FULL)
      |-> (out_count_i == ksr_pkg::COUNT_W'(DEPTH)))
    else $error("full reported below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_status_i == ksr_pkg::ST_EMPTY) |-> (out_count_i == '0))
    else $error("empty reported with entries held");

endmodule

bind keyed_stack_with_removal ksr_checker #(
  .DEPTH (DEPTH)
) u_ksr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.count)
);
